// ----- rtl/core/led_color_bit_slot_encoder_defines.svh -----
// Assertion macros used by the LED bit-slot encoder checker.
`ifndef LED_COLOR_BIT_SLOT_ENCODER_DEFINES_SVH
`define LED_COLOR_BIT_SLOT_ENCODER_DEFINES_SVH

// Check a property at every rising edge, skip while reset is asserted.
`define LCBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define LCBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/lcbs_pkg.sv -----
// Types and constants for the LED color bit-slot encoder.
package lcbs_pkg;

  localparam int unsigned BITS_PER_PIXEL  = 24;
  localparam int unsigned COMPARE_BITS    = 16;
  localparam int unsigned MAX_RESET_SLOTS = 64;
  localparam int unsigned COLOR_MAX       = 255;

  localparam int unsigned COUNT_W = 7;
  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;

  localparam logic [15:0]        ONE_CODE_RST    = 16'd60;
  localparam logic [15:0]        ZERO_CODE_RST   = 16'd30;
  localparam logic [COUNT_W-1:0] RESET_SLOTS_RST = 7'd50;

  localparam logic [15:0] COMPARE_MASK = 16'((32'd1 << COMPARE_BITS) - 32'd1);

  typedef enum logic [1:0] {
    REG_ONE_CODE    = 2'd0,
    REG_ZERO_CODE   = 2'd1,
    REG_RESET_SLOTS = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [15:0]        one_code_compare;
    logic [15:0]        zero_code_compare;
    logic [COUNT_W-1:0] reset_slot_count;
  } cfg_t;

  typedef struct packed {
    logic               command;
    logic signed [15:0] green;
    logic signed [15:0] red;
    logic signed [15:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [15:0] slot_compare;
    logic        last_slot;
  } out_item_t;

endpackage

// ----- rtl/core/led_color_bit_slot_encoder.sv -----
// A word waits in the holding register, moves to the slot shifter and sends its slots
// through the output register, one slot per cycle while the output is not stalled.
// A pixel word gives 24 slots and a latch word reset_slot_count slots clamped to 1..64,
// back to back, except that a one-slot latch leaves a gap before the next word starts.
// A one-word holding register takes the next word while the slot shifter is busy.
// Reset clears all valid flags and loads the registers with 60, 30 and 50.
module led_color_bit_slot_encoder
  import lcbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam logic [COUNT_W-1:0] PIXEL_SLOTS = COUNT_W'(BITS_PER_PIXEL);
  localparam logic [COUNT_W-1:0] MAX_SLOTS   = COUNT_W'(MAX_RESET_SLOTS);

  function automatic logic [7:0] clamp_color(input logic signed [15:0] v);
    logic [7:0] r;
    if (v < 16'sd0) begin
      r = 8'd0;
    end else if (v > 16'sd255) begin
      r = 8'(COLOR_MAX);
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  cfg_t cfg;

  lcbs_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // holding register
  logic                      pend_valid_q, pend_valid_d;
  logic                      pend_cmd_q, pend_cmd_d;
  logic [BITS_PER_PIXEL-1:0] pend_word_q, pend_word_d;
  logic [COUNT_W-1:0]        pend_cnt_q, pend_cnt_d;

  // slot shifter
  logic                      sh_busy_q, sh_busy_d;
  logic                      sh_cmd_q, sh_cmd_d;
  logic [BITS_PER_PIXEL-1:0] sh_word_q, sh_word_d;
  logic [COUNT_W-1:0]        sh_cnt_q, sh_cnt_d;

  // output register
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_item_q, out_item_d;

  logic               in_accept, out_adv, emit, emit_last, sh_load;
  logic [COUNT_W-1:0] latch_cnt;
  logic [15:0]        one_cmp, zero_cmp;

  assign in_stall_o = pend_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_adv    = !out_valid_q || !out_stall_i;
  assign emit       = sh_busy_q && out_adv;
  assign emit_last  = emit && (sh_cnt_q == COUNT_W'(1));
  assign sh_load    = pend_valid_q && (!sh_busy_q || emit_last);

  assign one_cmp  = cfg.one_code_compare & COMPARE_MASK;
  assign zero_cmp = cfg.zero_code_compare & COMPARE_MASK;

  always_comb begin
    if (cfg.reset_slot_count == '0) begin
      latch_cnt = COUNT_W'(1);
    end else if (cfg.reset_slot_count > MAX_SLOTS) begin
      latch_cnt = MAX_SLOTS;
    end else begin
      latch_cnt = cfg.reset_slot_count;
    end
  end

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_cmd_d   = pend_cmd_q;
    pend_word_d  = pend_word_q;
    pend_cnt_d   = pend_cnt_q;
    if (sh_load) begin
      pend_valid_d = 1'b0;
    end
    if (in_accept) begin
      pend_valid_d = 1'b1;
      pend_cmd_d   = in_item_i.command;
      pend_word_d  = {clamp_color(in_item_i.green),
                      clamp_color(in_item_i.red),
                      clamp_color(in_item_i.blue)};
      pend_cnt_d   = in_item_i.command ? latch_cnt : PIXEL_SLOTS;
    end
  end

  always_comb begin
    sh_busy_d = sh_busy_q;
    sh_cmd_d  = sh_cmd_q;
    sh_word_d = sh_word_q;
    sh_cnt_d  = sh_cnt_q;
    if (emit) begin
      sh_word_d = {sh_word_q[BITS_PER_PIXEL-2:0], 1'b0};
      sh_cnt_d  = sh_cnt_q - COUNT_W'(1);
      if (emit_last) begin
        sh_busy_d = 1'b0;
      end
    end
    if (sh_load) begin
      sh_busy_d = 1'b1;
      sh_cmd_d  = pend_cmd_q;
      sh_word_d = pend_word_q;
      sh_cnt_d  = pend_cnt_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (out_adv) begin
      out_valid_d = emit;
    end
    if (emit) begin
      // latch words send zero compare slots
      if (sh_cmd_q) begin
        out_item_d.slot_compare = '0;
      end else begin
        out_item_d.slot_compare = sh_word_q[BITS_PER_PIXEL-1] ? one_cmp : zero_cmp;
      end
      out_item_d.last_slot = emit_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      sh_busy_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      sh_busy_q    <= sh_busy_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cmd_q  <= pend_cmd_d;
    pend_word_q <= pend_word_d;
    pend_cnt_q  <= pend_cnt_d;
    sh_cmd_q    <= sh_cmd_d;
    sh_word_q   <= sh_word_d;
    sh_cnt_q    <= sh_cnt_d;
    out_item_q  <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- rtl/core/lcbs_cfg_regs.sv -----
// APB-style configuration registers of the LED bit-slot encoder.
module lcbs_cfg_regs
  import lcbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ONE_CODE:    cfg_d.one_code_compare  = pwdata[15:0];
        REG_ZERO_CODE:   cfg_d.zero_code_compare = pwdata[15:0];
        REG_RESET_SLOTS: cfg_d.reset_slot_count  = pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ONE_CODE:    prdata = {16'd0, cfg_q.one_code_compare};
      REG_ZERO_CODE:   prdata = {16'd0, cfg_q.zero_code_compare};
      REG_RESET_SLOTS: prdata = {{(DATA_W-COUNT_W){1'b0}}, cfg_q.reset_slot_count};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_code_compare  <= ONE_CODE_RST;
      cfg_q.zero_code_compare <= ZERO_CODE_RST;
      cfg_q.reset_slot_count  <= RESET_SLOTS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/core/lcbs_checker.sv -----
// Port-level checker for the LED bit-slot encoder, bound to the top level.
`include "led_color_bit_slot_encoder_defines.svh"

module lcbs_checker
  import lcbs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // no word leaves while reset is asserted
  `LCBS_ASSERT_ALWAYS(a_no_out_in_reset, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

  // a stalled word holds
  `LCBS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o), "stalled output word changed")

  // input stall is raised only by a word just taken
  `LCBS_ASSERT(a_stall_after_accept, clk_i, rst_ni, $rose(in_stall_o) |-> $past(in_valid_i && !in_stall_o), "input stall rose without an accepted word")

endmodule

bind led_color_bit_slot_encoder lcbs_checker u_lcbs_checker (.*);

// ----- sim/slot_checker.sv -----
// Slot checker: tracks the encoder registers, predicts every slot and compares it.
`timescale 1ns / 100ps
module slot_checker
  import lcbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_item_t          in_item_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_item_t         out_item_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  input  logic [DATA_W-1:0] prdata_i,
  input  logic              pready_i,
  output int                fail_count_o,
  output int                pending_o,
  output int                words_o,
  output int                latches_o,
  output int                slots_o
);

  logic [15:0]        one_code;
  logic [15:0]        zero_code;
  logic [COUNT_W-1:0] latch_len;
  out_item_t          expected_slots[$];

  int fails   = 0;
  int pending = 0;
  int words   = 0;
  int latches = 0;
  int slots   = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;
  assign words_o      = words;
  assign latches_o    = latches;
  assign slots_o      = slots;

  function automatic logic [7:0] clamp_intensity(input logic signed [15:0] v);
    if (v < 0) return 8'h00;
    if (v > 255) return 8'hFF;
    return v[7:0];
  endfunction

  // Expand one word into its slots: a latch gives zero-compare slots, a pixel walks GRB MSB first.
  task automatic queue_slots(input in_item_t w);
    logic [23:0] grb;
    int          n;
    out_item_t   s;
    if (w.command) begin
      n = (latch_len == 0) ? 1 : (latch_len > MAX_RESET_SLOTS) ? MAX_RESET_SLOTS : latch_len;
      for (int k = 0; k < n; k++) begin
        s.slot_compare = '0;
        s.last_slot    = (k == n - 1);
        expected_slots.push_back(s);
      end
    end else begin
      grb = {clamp_intensity(w.green), clamp_intensity(w.red), clamp_intensity(w.blue)};
      for (int k = 0; k < BITS_PER_PIXEL; k++) begin
        s.slot_compare = grb[BITS_PER_PIXEL-1-k] ? (one_code & COMPARE_MASK)
                                                 : (zero_code & COMPARE_MASK);
        s.last_slot    = (k == BITS_PER_PIXEL - 1);
        expected_slots.push_back(s);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t         want;
    logic [DATA_W-1:0] reg_val;
    logic              known;
    if (!rst_ni) begin
      one_code  = ONE_CODE_RST;
      zero_code = ZERO_CODE_RST;
      latch_len = RESET_SLOTS_RST;
      expected_slots.delete();
      pending = 0;
    end else begin
      if (psel_i && penable_i && pready_i) begin
        known = 1'b1;
        case (reg_idx_e'(paddr_i[ADDR_W-1:2]))
          REG_ONE_CODE: begin
            if (pwrite_i) one_code = pwdata_i[15:0];
            reg_val = {16'h0, one_code};
          end
          REG_ZERO_CODE: begin
            if (pwrite_i) zero_code = pwdata_i[15:0];
            reg_val = {16'h0, zero_code};
          end
          REG_RESET_SLOTS: begin
            if (pwrite_i) latch_len = pwdata_i[COUNT_W-1:0];
            reg_val = DATA_W'(latch_len);
          end
          default: begin
            known = 1'b0;
          end
        endcase
        if (!pwrite_i && known && prdata_i !== reg_val) begin
          $error("prdata: expected %0h, got %0h (paddr %0h)", reg_val, prdata_i, paddr_i);
          fails++;
        end
      end

      if (out_valid_i && !out_stall_i) begin
        slots++;
        if (expected_slots.size() == 0) begin
          $error("slot with nothing expected: slot_compare %0d last_slot %0b",
                 out_item_i.slot_compare, out_item_i.last_slot);
          fails++;
        end else begin
          want = expected_slots.pop_front();
          if (out_item_i.slot_compare !== want.slot_compare) begin
            $error("slot_compare: expected %0d, got %0d",
                   want.slot_compare, out_item_i.slot_compare);
            fails++;
          end
          if (out_item_i.last_slot !== want.last_slot) begin
            $error("last_slot: expected %0b, got %0b", want.last_slot, out_item_i.last_slot);
            fails++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        queue_slots(in_item_i);
        words++;
        if (in_item_i.command) latches++;
      end
      pending = expected_slots.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
// Testbench top: clock, reset, stimulus, register setup and verdict for the slot encoder.
`timescale 1ns / 100ps
module tb;
  import lcbs_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = {2'd3, 2'b00};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_word;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_word;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_ack      = 0;
  int hold_left     = 0;
  int cycles        = 0;
  int settings      = 0;
  int fails, pending, words, latches, slots;

  led_color_bit_slot_encoder DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_word),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  slot_checker u_slot_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_item_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_item_i   (out_word),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .fail_count_o (fails),
    .pending_o    (pending),
    .words_o      (words),
    .latches_o    (latches),
    .slots_o      (slots)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when the stimulus asks for one.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic in_item_t pixel_word(input logic signed [15:0] g, r, b);
    in_item_t w;
    w.command = 1'b0;
    w.green   = g;
    w.red     = r;
    w.blue    = b;
    return w;
  endfunction

  // Color fields of a latch are don't-care, so fill them with noise.
  function automatic in_item_t latch_word();
    in_item_t w;
    w.command = 1'b1;
    w.green   = 16'($urandom);
    w.red     = 16'($urandom);
    w.blue    = 16'($urandom);
    return w;
  endfunction

  function automatic logic signed [15:0] pick_intensity();
    case ($urandom_range(3))
      0, 1: return 16'($urandom_range(255));
      2: return 16'($urandom);
      default: begin
        case ($urandom_range(3))
          0: return 16'hFFFF;
          1: return 16'h0000;
          2: return 16'h00FF;
          default: return 16'h0100;
        endcase
      end
    endcase
  endfunction

  function automatic in_item_t random_word();
    if ($urandom_range(99) < 20) return latch_word();
    return pixel_word(pick_intensity(), pick_intensity(), pick_intensity());
  endfunction

  // Offer one word, holding it until accepted; returns on a falling edge.
  task automatic send_word(input in_item_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic [ADDR_W-1:0] addr, input logic wr,
                          input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write and read back all three registers once the encoder is idle.
  task automatic set_encoding(input logic [DATA_W-1:0] one, zero, count);
    in_valid <= 1'b0;
    @(negedge clk);
    wait_drained();
    apb_xfer({REG_ONE_CODE, 2'b00}, 1'b1, one);
    apb_xfer({REG_ZERO_CODE, 2'b00}, 1'b1, zero);
    apb_xfer({REG_RESET_SLOTS, 2'b00}, 1'b1, count);
    apb_xfer({REG_ONE_CODE, 2'b00}, 1'b0, '0);
    apb_xfer({REG_ZERO_CODE, 2'b00}, 1'b0, '0);
    apb_xfer({REG_RESET_SLOTS, 2'b00}, 1'b0, '0);
    settings++;
  endtask

  task automatic random_phase(input int n, input int idle, input int stall,
                              input bit pressure);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < n; i++) begin
      if (pressure && i == 8) hold_req++;
      if (pressure && i == 28) begin
        in_valid <= 1'b0;
        @(negedge clk);
        wait_drained();
      end
      send_word(random_word());
    end
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    rst_n   = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: clamp edges and the default latch length.
    send_word(pixel_word(16'h0000, 16'h0000, 16'h0000));
    send_word(pixel_word(16'h00FF, 16'h00FF, 16'h00FF));
    send_word(pixel_word(16'h8000, 16'h7FFF, 16'h0100));
    send_word(pixel_word(16'hFFFF, 16'h0080, 16'h0001));
    send_word(pixel_word(16'h00AA, 16'h0055, 16'h5555));
    send_word(latch_word());
    send_word(pixel_word(16'h0001, 16'hFF00, 16'h00FE));

    // Full-scale compare values and the one-slot latch.
    set_encoding(32'hABCD_FFFF, 32'hFFFF_0000, 32'd1);
    send_word(pixel_word(16'h00AA, 16'h0055, 16'h000F));
    send_word(latch_word());
    send_word(pixel_word(16'h00F0, 16'hFFFF, 16'h0100));

    set_encoding(32'h0, 32'h0000_FFFF, 32'd64);
    send_word(latch_word());
    send_word(pixel_word(16'h0080, 16'h0001, 16'h00FE));

    // Latch length of zero counts as one; above the maximum it saturates.
    set_encoding(32'd60, 32'd30, 32'd0);
    send_word(latch_word());
    set_encoding(32'd60, 32'd30, 32'd65);
    send_word(latch_word());
    set_encoding(32'd1234, 32'd77, 32'hFFFF_FF7F);
    send_word(latch_word());

    // A write to an unmapped register must change nothing.
    in_valid <= 1'b0;
    @(negedge clk);
    wait_drained();
    apb_xfer(UNMAPPED_ADDR, 1'b1, 32'hFFFF_FFFF);
    send_word(latch_word());
    send_word(pixel_word(16'h0099, 16'h0066, 16'h00C3));

    set_encoding($urandom_range(65535), $urandom_range(65535), $urandom_range(1, 24));
    random_phase(40, 0, 0, 1'b1);
    set_encoding($urandom_range(65535), $urandom_range(65535), $urandom_range(1, 64));
    random_phase(40, 51, 0, 1'b0);
    set_encoding($urandom_range(65535), $urandom_range(65535), $urandom_range(1, 16));
    random_phase(40, 0, 51, 1'b0);
    set_encoding($urandom_range(65535), $urandom_range(65535), $urandom_range(1, 32));
    random_phase(40, 21, 21, 1'b0);

    wait_drained();
    repeat (20) @(negedge clk);
    $display("Run covered %0d words (%0d latch codes) and %0d slots over %0d register settings,",
             words, latches, slots, settings);
    $display("with clamp edges, latch length extremes and four idle/stall mixes.");
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- led_color_bit_slot_encoder.f -----
+incdir+rtl/core
rtl/core/lcbs_pkg.sv
rtl/core/lcbs_cfg_regs.sv
rtl/core/led_color_bit_slot_encoder.sv
rtl/core/lcbs_checker.sv
sim/slot_checker.sv
sim/tb.sv
